>>> src/distinct_prime_factor_engine_unit_assert.svh
// Assertion macros used by the distinct prime factor engine controller.
`ifndef DISTINCT_PRIME_FACTOR_ENGINE_UNIT_ASSERT_SVH
`define DISTINCT_PRIME_FACTOR_ENGINE_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define DPFE_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: assertion failed");
`define DPFE_NEVER(name, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("%m: forbidden condition seen");
`else
`define DPFE_ASSERT(name, prop)
`define DPFE_NEVER(name, cond)
`endif
`endif

>>> src/dpfe_pkg.sv
// Shared constants, types and controller/datapath interface structs.
package dpfe_pkg;

  localparam int VALUE_BITS  = 31;
  localparam int SQ_BITS     = 2 * VALUE_BITS;
  localparam int MAX_RESULTS = 9;
  localparam int CNT_BITS    = $clog2(MAX_RESULTS + 1);
  localparam int STEP_BITS   = $clog2(VALUE_BITS);

  typedef logic [VALUE_BITS-1:0] value_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TEST,
    ST_DIV,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    SEL_NONE,
    SEL_REM,
    SEL_DIV
  } out_sel_e;

  typedef struct packed {
    logic     load;
    logic     div_start;
    logic     commit;
    logic     advance;
    logic     out_load;
    out_sel_e out_sel;
    logic     out_last;
  } dp_cmd_t;

  typedef struct packed {
    logic in_lt_two;
    logic sq_le_rem;
    logic rem_gt_one;
    logic div_done;
    logic rem_zero;
    logic out_last;
  } dp_status_t;

endpackage

>>> src/dpfe_datapath.sv
// Datapath: remaining value, trial divisor with its square, serial divider, result register.
module dpfe_datapath (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dpfe_pkg::value_t         value_i,
  input  dpfe_pkg::dp_cmd_t        cmd_i,
  output dpfe_pkg::dp_status_t     status_o,
  output dpfe_pkg::value_t         factor_o,
  output logic                     none_o,
  output logic                     last_o
);
  import dpfe_pkg::*;

  value_t                rem_q, rem_d;
  value_t                div_q, div_d;
  logic [SQ_BITS-1:0]    sq_q, sq_d;
  value_t                quo_q, quo_d;
  value_t                part_q, part_d;
  logic [STEP_BITS-1:0]  step_q, step_d;
  logic                  run_q, run_d;
  logic                  done_q, done_d;
  value_t                factor_q, factor_d;
  logic                  none_q, none_d;
  logic                  last_q, last_d;

  logic [VALUE_BITS:0]   trial;
  logic [VALUE_BITS:0]   diff;
  logic                  ge;

  always_comb begin
    trial = {part_q, quo_q[VALUE_BITS-1]};
    diff  = trial - {1'b0, div_q};
    ge    = (trial >= {1'b0, div_q});
  end

  always_comb begin
    rem_d    = rem_q;
    div_d    = div_q;
    sq_d     = sq_q;
    quo_d    = quo_q;
    part_d   = part_q;
    step_d   = step_q;
    run_d    = run_q;
    done_d   = 1'b0;
    factor_d = factor_q;
    none_d   = none_q;
    last_d   = last_q;

    if (run_q) begin
      part_d = ge ? diff[VALUE_BITS-1:0] : trial[VALUE_BITS-1:0];
      quo_d  = {quo_q[VALUE_BITS-2:0], ge};
      step_d = step_q + STEP_BITS'(1);
      if (step_q == STEP_BITS'(VALUE_BITS - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end

    if (cmd_i.load) begin
      rem_d = value_i;
      div_d = VALUE_BITS'(2);
      sq_d  = SQ_BITS'(4);
    end

    if (cmd_i.commit) begin
      rem_d = quo_q;
    end

    if (cmd_i.div_start) begin
      quo_d  = cmd_i.commit ? quo_q : rem_q;
      part_d = '0;
      step_d = '0;
      run_d  = 1'b1;
    end

    if (cmd_i.advance) begin
      if (div_q == VALUE_BITS'(2)) begin
        div_d = div_q + VALUE_BITS'(1);
        sq_d  = sq_q + SQ_BITS'({div_q, 1'b1});
      end else begin
        div_d = div_q + VALUE_BITS'(2);
        sq_d  = sq_q + SQ_BITS'({div_q, 2'b00}) + SQ_BITS'(4);
      end
    end

    if (cmd_i.out_load) begin
      case (cmd_i.out_sel)
        SEL_REM: factor_d = rem_q;
        SEL_DIV: factor_d = div_q;
        default: factor_d = '0;
      endcase
      none_d = (cmd_i.out_sel == SEL_NONE);
      last_d = cmd_i.out_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      div_q  <= '0;
      sq_q   <= '0;
      step_q <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      rem_q  <= rem_d;
      div_q  <= div_d;
      sq_q   <= sq_d;
      step_q <= step_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q    <= quo_d;
    part_q   <= part_d;
    factor_q <= factor_d;
    none_q   <= none_d;
    last_q   <= last_d;
  end

  always_comb begin
    status_o.in_lt_two  = (value_i < VALUE_BITS'(2));
    status_o.sq_le_rem  = (sq_q <= SQ_BITS'(rem_q));
    status_o.rem_gt_one = (rem_q > VALUE_BITS'(1));
    status_o.div_done   = done_q;
    status_o.rem_zero   = (part_q == '0);
    status_o.out_last   = last_q;
  end

  assign factor_o = factor_q;
  assign none_o   = none_q;
  assign last_o   = last_q;

endmodule

>>> src/dpfe_controller.sv
// Controller state machine: sequences divisor tests, divisions and result beats.
`include "distinct_prime_factor_engine_unit_assert.svh"
module dpfe_controller (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  dpfe_pkg::dp_status_t  status_i,
  output dpfe_pkg::dp_cmd_t     cmd_o
);
  import dpfe_pkg::*;

  state_e               state_q, state_d;
  logic [CNT_BITS-1:0]  cnt_q, cnt_d;
  logic                 found_q, found_d;
  logic                 room;

  assign room = (cnt_q < CNT_BITS'(MAX_RESULTS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      found_q <= found_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    found_d     = found_q;
    cmd_o       = '0;
    cmd_o.out_sel = SEL_NONE;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          found_d    = 1'b0;
          if (status_i.in_lt_two) begin
            cmd_o.out_load = 1'b1;
            cmd_o.out_sel  = SEL_NONE;
            cmd_o.out_last = 1'b1;
            state_d        = ST_EMIT;
          end else begin
            state_d = ST_TEST;
          end
        end
      end
      ST_TEST: begin
        if (room && status_i.sq_le_rem) begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV;
        end else if (room && status_i.rem_gt_one) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = SEL_REM;
          cmd_o.out_last = 1'b1;
          state_d        = ST_EMIT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (status_i.div_done) begin
          if (status_i.rem_zero) begin
            cmd_o.commit    = 1'b1;
            cmd_o.div_start = 1'b1;
            found_d         = 1'b1;
          end else if (found_q) begin
            cmd_o.out_load = 1'b1;
            cmd_o.out_sel  = SEL_DIV;
            cmd_o.out_last = !status_i.rem_gt_one ||
                             (cnt_q == CNT_BITS'(MAX_RESULTS - 1));
            state_d        = ST_EMIT;
          end else begin
            cmd_o.advance = 1'b1;
            state_d       = ST_TEST;
          end
        end
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cnt_d   = cnt_q + CNT_BITS'(1);
          found_d = 1'b0;
          if (status_i.out_last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.advance = 1'b1;
            state_d       = ST_TEST;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  `DPFE_NEVER(a_ready_while_holding, in_ready_o && out_valid_o)
  `DPFE_ASSERT(a_cnt_bounded, cnt_q <= CNT_BITS'(MAX_RESULTS))
  `DPFE_ASSERT(a_last_beat_idles, out_valid_o && out_ready_i && status_i.out_last |=> state_q == ST_IDLE)
  `DPFE_ASSERT(a_exact_div_repeats, state_q == ST_DIV && status_i.div_done && status_i.rem_zero |=> state_q == ST_DIV)

endmodule

>>> src/distinct_prime_factor_engine_unit.sv
// Top level of the distinct prime factor engine: controller plus datapath.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_ready_o   value_i
//   out      output     out_valid_o / out_ready_i factor_o, none_o, last_o
//
// One value is factored at a time; in_ready_o is high only while idle.
// Each trial divisor costs one serial division plus a test of the divisor's square.
// Divisors are tried up to the square root of what remains; repeated division of a found
// factor adds one more division per power. Reset returns the block to idle with no beat pending.
// A stalled output beat holds the whole engine until it is taken.
module distinct_prime_factor_engine_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [dpfe_pkg::VALUE_BITS-1:0] value_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [dpfe_pkg::VALUE_BITS-1:0] factor_o,
  output logic                       none_o,
  output logic                       last_o
);
  import dpfe_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  dpfe_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  dpfe_datapath u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .value_i  (value_i),
    .cmd_i    (cmd),
    .status_o (status),
    .factor_o (factor_o),
    .none_o   (none_o),
    .last_o   (last_o)
  );

endmodule
